// ----- hw/rtl/target_track_roi_and_search_scan_top_macros.svh -----
// Assertion macros for the target track and search scan block.
`ifndef TARGET_TRACK_ROI_AND_SEARCH_SCAN_TOP_MACROS_SVH
`define TARGET_TRACK_ROI_AND_SEARCH_SCAN_TOP_MACROS_SVH

// Same-cycle implication.
`define TTRS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define TTRS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/ttrs_pkg.sv -----
// Shared types and constants for the target track and search scan block.
package ttrs_pkg;

   localparam int ANG_W  = 16;
   localparam int CNT_W  = 16;
   localparam int ADDR_W = 5;
   localparam int DATA_W = 32;
   localparam int REG_IDX_W = 3;

   localparam int SCAN_STEP_DEF = 100;

   localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

   localparam logic [1:0] REQ_FRAME = 2'd0;
   localparam logic [1:0] REQ_TICK  = 2'd1;
   localparam logic [1:0] REQ_LOAD  = 2'd2;

   localparam logic [1:0] REGION_SMALL  = 2'd0;
   localparam logic [1:0] REGION_EXPAND = 2'd1;
   localparam logic [1:0] REGION_FULL   = 2'd2;

   localparam logic [REG_IDX_W-1:0] REG_LOCK_THR   = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_EXPAND_THR = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_FULL_THR   = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_SCAN_INT   = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_PAN_MIN    = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_PAN_MAX    = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_TILT_MIN   = 3'd6;
   localparam logic [REG_IDX_W-1:0] REG_TILT_MAX   = 3'd7;

   localparam logic [CNT_W-1:0]        LOCK_THR_RST   = 16'd5;
   localparam logic [CNT_W-1:0]        EXPAND_THR_RST = 16'd10;
   localparam logic [CNT_W-1:0]        FULL_THR_RST   = 16'd30;
   localparam logic [CNT_W-1:0]        SCAN_INT_RST   = 16'd20;
   localparam logic signed [ANG_W-1:0] PAN_MIN_RST    = -16'sd9000;
   localparam logic signed [ANG_W-1:0] PAN_MAX_RST    = 16'sd9000;
   localparam logic signed [ANG_W-1:0] TILT_MIN_RST   = -16'sd4500;
   localparam logic signed [ANG_W-1:0] TILT_MAX_RST   = 16'sd4500;

   typedef enum logic [2:0] {
      MODE_SMALL  = 3'b001,
      MODE_EXPAND = 3'b010,
      MODE_FULL   = 3'b100
   } mode_type;

   typedef struct packed {
      logic [CNT_W-1:0]        lock_thr;
      logic [CNT_W-1:0]        expand_thr;
      logic [CNT_W-1:0]        full_thr;
      logic [CNT_W-1:0]        scan_int;
      logic signed [ANG_W-1:0] pan_min;
      logic signed [ANG_W-1:0] pan_max;
      logic signed [ANG_W-1:0] tilt_min;
      logic signed [ANG_W-1:0] tilt_max;
   } cfg_type;

endpackage

// ----- hw/rtl/target_track_roi_and_search_scan_top.sv -----
// Top level of the target track, region mode and search scan block.
//
// Request channel (req_valid / req_stall): one item per frame result, timer
// tick or gimbal angle load, selected by req_type. Response channel
// (rsp_valid / rsp_stall): exactly one item per request, carrying region
// mode, scan flag, hit and miss counts and both angles after the request
// has been applied. Configuration goes through the APB-style port.
//
// An item accepted at one clock edge shows up on the response channel right
// after it. Throughput is one item per cycle unless rsp_stall holds a
// response; the tracker state registers double as the response register,
// and all update logic is one level of compare, add and clamp between them.
// While a response waits under rsp_stall, req_stall is raised so the state
// and the shown response hold; once the response is taken, a new request
// is accepted in the same cycle.
//
// Reset clears the response valid, puts the tracker in full frame mode with
// scanning off, counters and angles at zero, and loads the configuration
// defaults. Nothing else runs after reset.
`include "target_track_roi_and_search_scan_top_macros.svh"

module target_track_roi_and_search_scan_top #(
   parameter int SCAN_STEP = ttrs_pkg::SCAN_STEP_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [1:0]                           req_type,
   input  logic                                 req_detected,
   input  logic signed [ttrs_pkg::ANG_W-1:0]    req_pan_in,
   input  logic signed [ttrs_pkg::ANG_W-1:0]    req_tilt_in,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [1:0]                           rsp_region_mode,
   output logic                                 rsp_scan_active,
   output logic [ttrs_pkg::CNT_W-1:0]           rsp_hit_count,
   output logic [ttrs_pkg::CNT_W-1:0]           rsp_miss_count,
   output logic signed [ttrs_pkg::ANG_W-1:0]    rsp_pan_angle,
   output logic signed [ttrs_pkg::ANG_W-1:0]    rsp_tilt_angle,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [ttrs_pkg::ADDR_W-1:0]          paddr,
   input  logic [ttrs_pkg::DATA_W-1:0]          pwdata,
   output logic [ttrs_pkg::DATA_W-1:0]          prdata,
   output logic                                 pready
);

   localparam int ANG_W  = ttrs_pkg::ANG_W;
   localparam int STEP_W = $clog2(SCAN_STEP + 1) + 1;
   localparam int SUM_W  = ((ANG_W > STEP_W) ? ANG_W : STEP_W) + 1;
   localparam logic signed [SUM_W-1:0] STEP_S = SUM_W'(SCAN_STEP);

   ttrs_pkg::cfg_type                   cfg;
   logic                                accept;

   logic                                rsp_valid_ff;
   logic                                rsp_valid_in;
   ttrs_pkg::mode_type                  mode_ff;
   ttrs_pkg::mode_type                  mode_in;
   logic                                scan_ff;
   logic                                scan_in;
   logic [ttrs_pkg::CNT_W-1:0]          hit_ff;
   logic [ttrs_pkg::CNT_W-1:0]          hit_in;
   logic [ttrs_pkg::CNT_W-1:0]          miss_ff;
   logic [ttrs_pkg::CNT_W-1:0]          miss_in;
   logic [ttrs_pkg::CNT_W-1:0]          tick_ff;
   logic [ttrs_pkg::CNT_W-1:0]          tick_in;
   logic signed [ANG_W-1:0]             pan_ff;
   logic signed [ANG_W-1:0]             pan_in;
   logic signed [ANG_W-1:0]             tilt_ff;
   logic signed [ANG_W-1:0]             tilt_in;

   logic [ttrs_pkg::CNT_W-1:0]          hit_inc;
   logic [ttrs_pkg::CNT_W-1:0]          miss_inc;
   logic signed [SUM_W-1:0]             pan_step;
   logic signed [SUM_W-1:0]             tilt_step;
   logic signed [SUM_W-1:0]             pan_nx;
   logic signed [SUM_W-1:0]             tilt_nx;
   logic signed [SUM_W-1:0]             pan_lo;
   logic signed [SUM_W-1:0]             pan_hi;
   logic signed [SUM_W-1:0]             tilt_lo;
   logic signed [SUM_W-1:0]             tilt_hi;
   logic signed [SUM_W-1:0]             pan_clamp;
   logic signed [SUM_W-1:0]             tilt_clamp;

   function automatic logic signed [SUM_W-1:0] clamp_range(
      input logic signed [SUM_W-1:0] v,
      input logic signed [SUM_W-1:0] lo,
      input logic signed [SUM_W-1:0] hi
   );
      logic signed [SUM_W-1:0] r;
      if (v < lo) begin
         r = lo;
      end else if (v > hi) begin
         r = hi;
      end else begin
         r = v;
      end
      return r;
   endfunction

   ttrs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   assign hit_inc  = (hit_ff == ttrs_pkg::CNT_MAX) ? hit_ff : hit_ff + 1'b1;
   assign miss_inc = (miss_ff == ttrs_pkg::CNT_MAX) ? miss_ff : miss_ff + 1'b1;

   assign pan_lo  = SUM_W'(cfg.pan_min);
   assign pan_hi  = SUM_W'(cfg.pan_max);
   assign tilt_lo = SUM_W'(cfg.tilt_min);
   assign tilt_hi = SUM_W'(cfg.tilt_max);

   assign pan_step  = SUM_W'(pan_ff) + STEP_S;
   assign tilt_step = SUM_W'(tilt_ff) + STEP_S;

   always_comb begin
      pan_nx  = pan_step;
      tilt_nx = SUM_W'(tilt_ff);
      if (pan_step > pan_hi) begin
         pan_nx  = pan_lo;
         tilt_nx = (tilt_step > tilt_hi) ? tilt_lo : tilt_step;
      end
   end

   assign pan_clamp  = clamp_range(pan_nx, pan_lo, pan_hi);
   assign tilt_clamp = clamp_range(tilt_nx, tilt_lo, tilt_hi);

   always_comb begin
      mode_in = mode_ff;
      scan_in = scan_ff;
      hit_in  = hit_ff;
      miss_in = miss_ff;
      tick_in = tick_ff;
      pan_in  = pan_ff;
      tilt_in = tilt_ff;
      if (accept) begin
         case (req_type)
            ttrs_pkg::REQ_FRAME: begin
               if (req_detected) begin
                  miss_in = '0;
                  hit_in  = hit_inc;
                  if (hit_inc >= cfg.lock_thr && mode_ff != ttrs_pkg::MODE_SMALL) begin
                     mode_in = ttrs_pkg::MODE_SMALL;
                     scan_in = 1'b0;
                  end
               end else begin
                  hit_in  = '0;
                  miss_in = miss_inc;
                  if (miss_inc >= cfg.expand_thr && mode_ff == ttrs_pkg::MODE_SMALL) begin
                     mode_in = ttrs_pkg::MODE_EXPAND;
                  end
                  if (miss_inc >= cfg.full_thr && mode_ff != ttrs_pkg::MODE_FULL) begin
                     mode_in = ttrs_pkg::MODE_FULL;
                     scan_in = 1'b1;
                  end
               end
            end
            ttrs_pkg::REQ_TICK: begin
               if (scan_ff) begin
                  if (tick_ff < cfg.scan_int) begin
                     tick_in = tick_ff + 1'b1;
                  end else begin
                     tick_in = '0;
                     pan_in  = pan_clamp[ANG_W-1:0];
                     tilt_in = tilt_clamp[ANG_W-1:0];
                  end
               end
            end
            ttrs_pkg::REQ_LOAD: begin
               pan_in  = req_pan_in;
               tilt_in = req_tilt_in;
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         mode_ff      <= ttrs_pkg::MODE_FULL;
         scan_ff      <= 1'b0;
         hit_ff       <= '0;
         miss_ff      <= '0;
         tick_ff      <= '0;
         pan_ff       <= '0;
         tilt_ff      <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         mode_ff      <= mode_in;
         scan_ff      <= scan_in;
         hit_ff       <= hit_in;
         miss_ff      <= miss_in;
         tick_ff      <= tick_in;
         pan_ff       <= pan_in;
         tilt_ff      <= tilt_in;
      end
   end

   always_comb begin
      case (mode_ff)
         ttrs_pkg::MODE_SMALL:  rsp_region_mode = ttrs_pkg::REGION_SMALL;
         ttrs_pkg::MODE_EXPAND: rsp_region_mode = ttrs_pkg::REGION_EXPAND;
         default:               rsp_region_mode = ttrs_pkg::REGION_FULL;
      endcase
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_scan_active = scan_ff;
   assign rsp_hit_count   = hit_ff;
   assign rsp_miss_count  = miss_ff;
   assign rsp_pan_angle   = pan_ff;
   assign rsp_tilt_angle  = tilt_ff;

   `TTRS_ASSERT_NXT(a_accept_gives_rsp, clock, reset, accept, rsp_valid_ff, "accepted item lost")
   `TTRS_ASSERT_IMP(a_scan_full, clock, reset, scan_ff, mode_ff == ttrs_pkg::MODE_FULL, "scan off full")
   `TTRS_ASSERT_IMP(a_hit_miss_excl, clock, reset, hit_ff != '0, miss_ff == '0, "hit with miss")
   `TTRS_ASSERT_NXT(a_tick_idle_hold, clock, reset, !scan_ff, $stable(tick_ff), "tick moved idle")

endmodule

// ----- hw/rtl/ttrs_csr.sv -----
// Configuration register file with its APB-style access port.
module ttrs_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [ttrs_pkg::ADDR_W-1:0]   paddr,
   input  logic [ttrs_pkg::DATA_W-1:0]   pwdata,
   output logic [ttrs_pkg::DATA_W-1:0]   prdata,
   output logic                          pready,
   output ttrs_pkg::cfg_type             cfg
);

   ttrs_pkg::cfg_type                  cfg_ff;
   ttrs_pkg::cfg_type                  cfg_in;
   logic                               wr_en;
   logic [ttrs_pkg::REG_IDX_W-1:0]     reg_idx;
   logic [ttrs_pkg::CNT_W-1:0]         wr_data;
   logic [ttrs_pkg::CNT_W-1:0]         rd_data;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite & pready;
   assign reg_idx = paddr[ttrs_pkg::ADDR_W-1:2];
   assign wr_data = pwdata[ttrs_pkg::CNT_W-1:0];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            ttrs_pkg::REG_LOCK_THR:   cfg_in.lock_thr   = wr_data;
            ttrs_pkg::REG_EXPAND_THR: cfg_in.expand_thr = wr_data;
            ttrs_pkg::REG_FULL_THR:   cfg_in.full_thr   = wr_data;
            ttrs_pkg::REG_SCAN_INT:   cfg_in.scan_int   = wr_data;
            ttrs_pkg::REG_PAN_MIN:    cfg_in.pan_min    = wr_data;
            ttrs_pkg::REG_PAN_MAX:    cfg_in.pan_max    = wr_data;
            ttrs_pkg::REG_TILT_MIN:   cfg_in.tilt_min   = wr_data;
            ttrs_pkg::REG_TILT_MAX:   cfg_in.tilt_max   = wr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.lock_thr   <= ttrs_pkg::LOCK_THR_RST;
         cfg_ff.expand_thr <= ttrs_pkg::EXPAND_THR_RST;
         cfg_ff.full_thr   <= ttrs_pkg::FULL_THR_RST;
         cfg_ff.scan_int   <= ttrs_pkg::SCAN_INT_RST;
         cfg_ff.pan_min    <= ttrs_pkg::PAN_MIN_RST;
         cfg_ff.pan_max    <= ttrs_pkg::PAN_MAX_RST;
         cfg_ff.tilt_min   <= ttrs_pkg::TILT_MIN_RST;
         cfg_ff.tilt_max   <= ttrs_pkg::TILT_MAX_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_idx)
         ttrs_pkg::REG_LOCK_THR:   rd_data = cfg_ff.lock_thr;
         ttrs_pkg::REG_EXPAND_THR: rd_data = cfg_ff.expand_thr;
         ttrs_pkg::REG_FULL_THR:   rd_data = cfg_ff.full_thr;
         ttrs_pkg::REG_SCAN_INT:   rd_data = cfg_ff.scan_int;
         ttrs_pkg::REG_PAN_MIN:    rd_data = cfg_ff.pan_min;
         ttrs_pkg::REG_PAN_MAX:    rd_data = cfg_ff.pan_max;
         ttrs_pkg::REG_TILT_MIN:   rd_data = cfg_ff.tilt_min;
         ttrs_pkg::REG_TILT_MAX:   rd_data = cfg_ff.tilt_max;
         default:                  rd_data = '0;
      endcase
   end

   assign prdata = {{(ttrs_pkg::DATA_W-ttrs_pkg::CNT_W){1'b0}}, rd_data};
   assign cfg    = cfg_ff;

endmodule

// ----- tb/tb.sv -----
// Testbench for the target tracker with region mode selection and search scan.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ANG_W       = ttrs_pkg::ANG_W;
   localparam int CNT_W       = ttrs_pkg::CNT_W;
   localparam int SCAN_STEP   = ttrs_pkg::SCAN_STEP_DEF;
   localparam int STUCK_LIMIT = 2000;
   localparam int HOLD_LEN    = 300;
   localparam int MAX_REPORTS = 10;

   localparam logic [1:0] REQ_UNUSED = 2'd3;

   localparam int SET_RANDOM = 0;
   localparam int SET_LOW    = 1;
   localparam int SET_HIGH   = 2;

   typedef struct packed {
      logic [1:0]              region;
      logic                    scanning;
      logic [CNT_W-1:0]        hits;
      logic [CNT_W-1:0]        misses;
      logic signed [ANG_W-1:0] pan;
      logic signed [ANG_W-1:0] tilt;
   } track_status_type;

   function automatic logic signed [ANG_W-1:0] clamp_angle(int v, int lo, int hi);
      if (v < lo) begin
         return lo[ANG_W-1:0];
      end
      if (v > hi) begin
         return hi[ANG_W-1:0];
      end
      return v[ANG_W-1:0];
   endfunction

   class track_scoreboard_type;
      track_status_type expected_status[$];
      int failures;
      logic [CNT_W-1:0] lock_thr, expand_thr, full_thr, scan_int;
      logic signed [ANG_W-1:0] pan_min, pan_max, tilt_min, tilt_max;
      logic [1:0] region;
      logic scanning;
      logic [CNT_W-1:0] hits, misses, ticks;
      logic signed [ANG_W-1:0] pan, tilt;

      function new();
         failures   = 0;
         lock_thr   = ttrs_pkg::LOCK_THR_RST;
         expand_thr = ttrs_pkg::EXPAND_THR_RST;
         full_thr   = ttrs_pkg::FULL_THR_RST;
         scan_int   = ttrs_pkg::SCAN_INT_RST;
         pan_min    = ttrs_pkg::PAN_MIN_RST;
         pan_max    = ttrs_pkg::PAN_MAX_RST;
         tilt_min   = ttrs_pkg::TILT_MIN_RST;
         tilt_max   = ttrs_pkg::TILT_MAX_RST;
         region     = ttrs_pkg::REGION_FULL;
         scanning   = 1'b0;
         hits       = '0;
         misses     = '0;
         ticks      = '0;
         pan        = '0;
         tilt       = '0;
      endfunction

      function void set_reg(logic [ttrs_pkg::REG_IDX_W-1:0] idx, logic [CNT_W-1:0] value);
         case (idx)
            ttrs_pkg::REG_LOCK_THR:   lock_thr = value;
            ttrs_pkg::REG_EXPAND_THR: expand_thr = value;
            ttrs_pkg::REG_FULL_THR:   full_thr = value;
            ttrs_pkg::REG_SCAN_INT:   scan_int = value;
            ttrs_pkg::REG_PAN_MIN:    pan_min = value;
            ttrs_pkg::REG_PAN_MAX:    pan_max = value;
            ttrs_pkg::REG_TILT_MIN:   tilt_min = value;
            ttrs_pkg::REG_TILT_MAX:   tilt_max = value;
            default: ;
         endcase
      endfunction

      function void note_item(logic [1:0] kind, logic det,
                              logic signed [ANG_W-1:0] pan_in,
                              logic signed [ANG_W-1:0] tilt_in);
         int p;
         int t;
         case (kind)
            ttrs_pkg::REQ_FRAME: begin
               if (det) begin
                  misses = '0;
                  if (hits != ttrs_pkg::CNT_MAX) begin
                     hits++;
                  end
                  if (hits >= lock_thr && region != ttrs_pkg::REGION_SMALL) begin
                     region   = ttrs_pkg::REGION_SMALL;
                     scanning = 1'b0;
                  end
               end else begin
                  hits = '0;
                  if (misses != ttrs_pkg::CNT_MAX) begin
                     misses++;
                  end
                  if (misses >= expand_thr && region == ttrs_pkg::REGION_SMALL) begin
                     region = ttrs_pkg::REGION_EXPAND;
                  end
                  if (misses >= full_thr && region != ttrs_pkg::REGION_FULL) begin
                     region   = ttrs_pkg::REGION_FULL;
                     scanning = 1'b1;
                  end
               end
            end
            ttrs_pkg::REQ_TICK: begin
               if (scanning) begin
                  if (ticks < scan_int) begin
                     ticks++;
                  end else begin
                     ticks = '0;
                     p = int'(pan) + SCAN_STEP;
                     t = int'(tilt);
                     if (p > pan_max) begin
                        p = pan_min;
                        t = t + SCAN_STEP;
                        if (t > tilt_max) begin
                           t = tilt_min;
                        end
                     end
                     pan  = clamp_angle(p, pan_min, pan_max);
                     tilt = clamp_angle(t, tilt_min, tilt_max);
                  end
               end
            end
            ttrs_pkg::REQ_LOAD: begin
               pan  = pan_in;
               tilt = tilt_in;
            end
            default: ;
         endcase
         expected_status.push_back('{region, scanning, hits, misses, pan, tilt});
      endfunction

      function void check_result(track_status_type got);
         track_status_type want;
         if (expected_status.size() == 0) begin
            failures++;
            if (failures <= MAX_REPORTS) begin
               $display("unexpected status item: mode %0d scan %0d hits %0d misses %0d",
                        got.region, got.scanning, got.hits, got.misses);
            end
            return;
         end
         want = expected_status.pop_front();
         if (got.region !== want.region || got.scanning !== want.scanning ||
             got.hits !== want.hits || got.misses !== want.misses ||
             got.pan !== want.pan || got.tilt !== want.tilt) begin
            failures++;
            if (failures <= MAX_REPORTS) begin
               $display({"status mismatch: expected mode %0d scan %0d hits %0d",
                         " misses %0d pan %0d tilt %0d"},
                        want.region, want.scanning, want.hits, want.misses, want.pan,
                        want.tilt);
               $display({"                 got      mode %0d scan %0d hits %0d",
                         " misses %0d pan %0d tilt %0d"},
                        got.region, got.scanning, got.hits, got.misses, got.pan, got.tilt);
            end
         end
      endfunction

      function int pending();
         return expected_status.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_type = ttrs_pkg::REQ_FRAME;
   logic req_detected = 1'b0;
   logic signed [ANG_W-1:0] req_pan_in = '0;
   logic signed [ANG_W-1:0] req_tilt_in = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [1:0] rsp_region_mode;
   logic rsp_scan_active;
   logic [CNT_W-1:0] rsp_hit_count;
   logic [CNT_W-1:0] rsp_miss_count;
   logic signed [ANG_W-1:0] rsp_pan_angle;
   logic signed [ANG_W-1:0] rsp_tilt_angle;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [ttrs_pkg::ADDR_W-1:0] paddr = '0;
   logic [ttrs_pkg::DATA_W-1:0] pwdata = '0;
   logic [ttrs_pkg::DATA_W-1:0] prdata;
   logic pready;

   track_scoreboard_type sb;
   int send_gap_pct = 0;
   int recv_stall_pct = 0;
   int hold_cycles = 0;
   int stuck_cycles = 0;

   target_track_roi_and_search_scan_top #(.SCAN_STEP(SCAN_STEP)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_type(req_type),
      .req_detected(req_detected), .req_pan_in(req_pan_in), .req_tilt_in(req_tilt_in),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_region_mode(rsp_region_mode),
      .rsp_scan_active(rsp_scan_active), .rsp_hit_count(rsp_hit_count),
      .rsp_miss_count(rsp_miss_count), .rsp_pan_angle(rsp_pan_angle),
      .rsp_tilt_angle(rsp_tilt_angle),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
      .prdata(prdata), .pready(pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles = hold_cycles - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_result(track_status_type'({rsp_region_mode, rsp_scan_active,
                                             rsp_hit_count, rsp_miss_count,
                                             rsp_pan_angle, rsp_tilt_angle}));
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            stuck_cycles = 0;
         end else begin
            stuck_cycles = stuck_cycles + 1;
         end
         if (stuck_cycles >= STUCK_LIMIT) begin
            $display("tb failed");
            $finish;
         end
      end
   end

   function automatic int clip_angle(int v);
      if (v < -18000) begin
         return -18000;
      end
      if (v > 18000) begin
         return 18000;
      end
      return v;
   endfunction

   function automatic int rand_angle();
      return int'($urandom_range(36000)) - 18000;
   endfunction

   function automatic int pick_angle(int lo, int hi);
      case ($urandom_range(2))
         0: return rand_angle();
         1: return clip_angle(lo + int'($urandom_range(400)) - 200);
         default: return clip_angle(hi + int'($urandom_range(400)) - 200);
      endcase
   endfunction

   task automatic send_item(logic [1:0] kind, logic det, int pan_v, int tilt_v);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_type     <= kind;
      req_detected <= det;
      req_pan_in   <= pan_v[ANG_W-1:0];
      req_tilt_in  <= tilt_v[ANG_W-1:0];
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      sb.note_item(kind, det, pan_v[ANG_W-1:0], tilt_v[ANG_W-1:0]);
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) begin
         @(negedge clock);
      end
      repeat (2) @(negedge clock);
   endtask

   task automatic csr_write(logic [ttrs_pkg::REG_IDX_W-1:0] idx, int value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= {16'h0, value[15:0]};
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) begin
         @(posedge clock);
      end
      sb.set_reg(idx, value[15:0]);
      @(negedge clock);
   endtask

   task automatic program_settings(int style);
      int lock_v, expand_v, full_v, int_v;
      int pmin, pmax, tmin, tmax, mid, half, swap;
      case (style)
         SET_LOW: begin
            lock_v = 1; expand_v = 1; full_v = 1; int_v = 0;
            pmin = -18000; pmax = 18000; tmin = -18000; tmax = 18000;
         end
         SET_HIGH: begin
            lock_v = 65535; expand_v = 65535; full_v = 65535; int_v = 65535;
            pmin = -18000; pmax = 18000; tmin = -18000; tmax = 18000;
         end
         default: begin
            lock_v   = $urandom_range(6, 1);
            expand_v = $urandom_range(8, 1);
            full_v   = $urandom_range(12, 1);
            int_v    = $urandom_range(3);
            mid  = rand_angle();
            half = $urandom_range(400);
            pmin = clip_angle(mid - half);
            pmax = clip_angle(mid + half);
            mid  = rand_angle();
            half = $urandom_range(300);
            tmin = clip_angle(mid - half);
            tmax = clip_angle(mid + half);
            if ($urandom_range(5) == 0) begin
               swap = pmin; pmin = pmax; pmax = swap;
            end
            if ($urandom_range(5) == 0) begin
               swap = tmin; tmin = tmax; tmax = swap;
            end
         end
      endcase
      csr_write(ttrs_pkg::REG_LOCK_THR, lock_v);
      csr_write(ttrs_pkg::REG_EXPAND_THR, expand_v);
      csr_write(ttrs_pkg::REG_FULL_THR, full_v);
      csr_write(ttrs_pkg::REG_SCAN_INT, int_v);
      csr_write(ttrs_pkg::REG_PAN_MIN, pmin);
      csr_write(ttrs_pkg::REG_PAN_MAX, pmax);
      csr_write(ttrs_pkg::REG_TILT_MIN, tmin);
      csr_write(ttrs_pkg::REG_TILT_MAX, tmax);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   task automatic run_random(int n, bit with_hold);
      int sent, pick, len;
      bit held;
      logic det;
      sent = 0;
      held = 1'b0;
      while (sent < n) begin
         if (with_hold && !held && sent >= n / 2) begin
            hold_cycles = HOLD_LEN;
            held = 1'b1;
         end
         pick = $urandom_range(99);
         if (pick < 40) begin
            len = $urandom_range(14, 1);
            det = 1'($urandom_range(1));
            repeat (len) send_item(ttrs_pkg::REQ_FRAME, det, rand_angle(), rand_angle());
            sent += len;
         end else if (pick < 78) begin
            len = $urandom_range(8, 1);
            repeat (len) send_item(ttrs_pkg::REQ_TICK, 1'($urandom_range(1)), rand_angle(),
                                   rand_angle());
            sent += len;
         end else if (pick < 92) begin
            send_item(ttrs_pkg::REQ_LOAD, 1'($urandom_range(1)),
                      pick_angle(sb.pan_min, sb.pan_max),
                      pick_angle(sb.tilt_min, sb.tilt_max));
            sent++;
         end else if (pick < 97) begin
            send_item(ttrs_pkg::REQ_FRAME, 1'($urandom_range(1)), rand_angle(), rand_angle());
            sent++;
         end else begin
            send_item(REQ_UNUSED, 1'($urandom_range(1)), rand_angle(), rand_angle());
            sent++;
         end
      end
   endtask

   initial begin
      sb = new();
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      csr_write(ttrs_pkg::REG_LOCK_THR, 2);
      csr_write(ttrs_pkg::REG_EXPAND_THR, 2);
      csr_write(ttrs_pkg::REG_FULL_THR, 3);
      csr_write(ttrs_pkg::REG_SCAN_INT, 1);
      csr_write(ttrs_pkg::REG_PAN_MIN, -200);
      csr_write(ttrs_pkg::REG_PAN_MAX, 200);
      csr_write(ttrs_pkg::REG_TILT_MIN, -100);
      csr_write(ttrs_pkg::REG_TILT_MAX, 100);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);

      send_item(REQ_UNUSED, 1'b1, -1, -1);
      send_item(ttrs_pkg::REQ_TICK, 1'b0, 0, 0);
      send_item(ttrs_pkg::REQ_LOAD, 1'b0, 18000, -18000);
      repeat (2) send_item(ttrs_pkg::REQ_FRAME, 1'b1, 0, 0);
      repeat (3) send_item(ttrs_pkg::REQ_FRAME, 1'b0, 0, 0);
      repeat (2) send_item(ttrs_pkg::REQ_TICK, 1'b0, 0, 0);
      send_item(ttrs_pkg::REQ_LOAD, 1'b1, 150, 100);
      repeat (2) send_item(ttrs_pkg::REQ_TICK, 1'b0, 0, 0);
      send_item(ttrs_pkg::REQ_LOAD, 1'b0, -18000, 18000);
      repeat (2) send_item(ttrs_pkg::REQ_TICK, 1'b1, 0, 0);
      repeat (2) send_item(ttrs_pkg::REQ_FRAME, 1'b1, 0, 0);
      send_item(ttrs_pkg::REQ_TICK, 1'b0, 0, 0);
      wait_idle();

      // inverted pan and tilt bounds
      csr_write(ttrs_pkg::REG_PAN_MIN, 300);
      csr_write(ttrs_pkg::REG_PAN_MAX, -300);
      csr_write(ttrs_pkg::REG_TILT_MIN, 50);
      csr_write(ttrs_pkg::REG_TILT_MAX, -50);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      repeat (3) send_item(ttrs_pkg::REQ_FRAME, 1'b0, 0, 0);
      send_item(ttrs_pkg::REQ_LOAD, 1'b0, 0, 0);
      repeat (4) send_item(ttrs_pkg::REQ_TICK, 1'b0, 0, 0);

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_gap_pct = 13;
               recv_stall_pct = 87;
            end
            1: begin
               send_gap_pct = 87;
               recv_stall_pct = 13;
            end
            default: begin
               send_gap_pct = 0;
               recv_stall_pct = 0;
            end
         endcase
         for (int sub = 0; sub < 3; sub++) begin
            wait_idle();
            if (phase == 0 && sub == 0) begin
               program_settings(SET_LOW);
            end else if (phase == 2 && sub == 0) begin
               program_settings(SET_HIGH);
            end else begin
               program_settings(SET_RANDOM);
            end
            run_random(217, sub == 1);
         end
      end

      wait_idle();
      repeat (4) @(negedge clock);
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end
endmodule
